FILE: design/pmla_pkg.sv
package pmla_pkg;

    // table size and fixed-point format
    localparam int NUM_METHODS = 16;
    localparam int FRAC_BITS   = 11;

    // field widths
    localparam int IDX_W  = 4;
    localparam int TIME_W = 31;
    localparam int CNT_W  = 32;
    localparam int MASK_W = 16;

    // storage widths
    localparam int MW        = (NUM_METHODS > 2) ? $clog2(NUM_METHODS) : 1;
    localparam int NUM_AVG   = 3;
    localparam int K_W       = 2;
    localparam int AVG_DEPTH = NUM_METHODS * NUM_AVG;
    localparam int AW        = $clog2(AVG_DEPTH);
    localparam int TAVG_W    = TIME_W + FRAC_BITS;
    localparam int RAVG_W    = CNT_W + FRAC_BITS;
    localparam int COEF_W    = FRAC_BITS;

    localparam logic [K_W-1:0] K_LAST = K_W'(NUM_AVG - 1);

    // opcodes
    localparam logic OP_CALL = 1'b0;
    localparam logic OP_TICK = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CALL_WR,
        ST_SCAN,
        ST_LOAD,
        ST_MUL,
        ST_ADD,
        ST_EMIT
    } pmla_state_t;

    typedef struct packed {
        logic           call_rd;
        logic           call_wr;
        logic           tick_rd;
        logic           load;
        logic           mul;
        logic           add;
        logic           emit;
        logic [MW-1:0]  m;
        logic [K_W-1:0] k;
    } pmla_cmd_t;

    typedef struct packed {
        logic call_ok;
        logic any_seen;
        logic seen_cur;
        logic is_last;
        logic out_free;
    } pmla_sts_t;

    // decay factors out of 2**FRAC_BITS: 1, 5 and 15 minute constants
    function automatic logic [COEF_W-1:0] decay_coef(input logic [K_W-1:0] k);
        logic [COEF_W-1:0] c;
        begin
            case (k)
                2'd0:    c = COEF_W'(1884);
                2'd1:    c = COEF_W'(2014);
                2'd2:    c = COEF_W'(2037);
                default: c = '0;
            endcase
            return c;
        end
    endfunction

    function automatic logic [COEF_W-1:0] decay_comp(input logic [K_W-1:0] k);
        begin
            return COEF_W'((2 ** FRAC_BITS) - int'(decay_coef(k)));
        end
    endfunction

endpackage

FILE: design/pmla_if.sv
interface pmla_req_if;
    logic                             valid;
    logic                             ready;
    logic                             opcode;
    logic [pmla_pkg::IDX_W-1:0]       method_index;
    logic [pmla_pkg::TIME_W-1:0]      call_time;

    modport source (output valid, output opcode, output method_index, output call_time,
                    input ready);
    modport sink   (input valid, input opcode, input method_index, input call_time,
                    output ready);
endinterface

interface pmla_rsp_if;
    logic                             valid;
    logic                             ready;
    logic [pmla_pkg::IDX_W-1:0]       method_id;
    logic [pmla_pkg::TIME_W-1:0]      mean_time_short;
    logic [pmla_pkg::TIME_W-1:0]      mean_time_mid;
    logic [pmla_pkg::TIME_W-1:0]      mean_time_long;
    logic [pmla_pkg::CNT_W-1:0]       rate_short;
    logic [pmla_pkg::CNT_W-1:0]       rate_mid;
    logic [pmla_pkg::CNT_W-1:0]       rate_long;
    logic                             last;

    modport source (output valid, output method_id, output mean_time_short,
                    output mean_time_mid, output mean_time_long, output rate_short,
                    output rate_mid, output rate_long, output last, input ready);
    modport sink   (input valid, input method_id, input mean_time_short,
                    input mean_time_mid, input mean_time_long, input rate_short,
                    input rate_mid, input rate_long, input last, output ready);
endinterface

interface pmla_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [pmla_pkg::MASK_W-1:0]      data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: design/pmla_ctrl.sv
module pmla_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    input  logic                req_opcode,
    output logic                req_ready,
    input  pmla_pkg::pmla_sts_t sts,
    output pmla_pkg::pmla_cmd_t cmd
);

    pmla_pkg::pmla_state_t           state_reg, state_next;
    logic [pmla_pkg::MW-1:0]         m_reg, m_next;
    logic [pmla_pkg::K_W-1:0]        k_reg, k_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pmla_pkg::ST_IDLE;
            m_reg     <= '0;
            k_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            m_reg     <= m_next;
            k_reg     <= k_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        m_next     = m_reg;
        k_next     = k_reg;
        unique case (state_reg)
            pmla_pkg::ST_IDLE:
            begin
                if (req_valid)
                begin
                    if (req_opcode == pmla_pkg::OP_CALL)
                    begin
                        if (sts.call_ok)
                            state_next = pmla_pkg::ST_CALL_WR;
                    end
                    else if (sts.any_seen)
                    begin
                        state_next = pmla_pkg::ST_SCAN;
                        m_next     = '0;
                    end
                end
            end
            pmla_pkg::ST_CALL_WR:
                state_next = pmla_pkg::ST_IDLE;
            pmla_pkg::ST_SCAN:
            begin
                if (sts.seen_cur)
                begin
                    state_next = pmla_pkg::ST_LOAD;
                    k_next     = '0;
                end
                else
                    m_next = m_reg + 1'b1;
            end
            pmla_pkg::ST_LOAD:
                state_next = pmla_pkg::ST_MUL;
            pmla_pkg::ST_MUL:
                state_next = pmla_pkg::ST_ADD;
            pmla_pkg::ST_ADD:
            begin
                if (k_reg == pmla_pkg::K_LAST)
                    state_next = pmla_pkg::ST_EMIT;
                else
                begin
                    state_next = pmla_pkg::ST_MUL;
                    k_next     = k_reg + 1'b1;
                end
            end
            pmla_pkg::ST_EMIT:
            begin
                if (sts.out_free)
                begin
                    if (sts.is_last)
                        state_next = pmla_pkg::ST_IDLE;
                    else
                    begin
                        state_next = pmla_pkg::ST_SCAN;
                        m_next     = m_reg + 1'b1;
                    end
                end
            end
            default:
                state_next = pmla_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        req_ready   = 1'b0;
        cmd         = '0;
        cmd.m       = m_reg;
        cmd.k       = k_reg;
        unique case (state_reg)
            pmla_pkg::ST_IDLE:
            begin
                req_ready   = 1'b1;
                cmd.call_rd = req_valid && (req_opcode == pmla_pkg::OP_CALL) && sts.call_ok;
            end
            pmla_pkg::ST_CALL_WR: cmd.call_wr = 1'b1;
            pmla_pkg::ST_SCAN:    cmd.tick_rd = sts.seen_cur;
            pmla_pkg::ST_LOAD:    cmd.load    = 1'b1;
            pmla_pkg::ST_MUL:     cmd.mul     = 1'b1;
            pmla_pkg::ST_ADD:     cmd.add     = 1'b1;
            pmla_pkg::ST_EMIT:    cmd.emit    = sts.out_free;
            default:              req_ready   = 1'b0;
        endcase
    end

endmodule

FILE: design/pmla_dp.sv
module pmla_dp (
    input  logic                clk,
    input  logic                rst_n,
    pmla_req_if.sink            req,
    pmla_rsp_if.source          rsp,
    pmla_cfg_if.sink            cfg,
    input  pmla_pkg::pmla_cmd_t cmd,
    output pmla_pkg::pmla_sts_t sts
);

    localparam int MW     = pmla_pkg::MW;
    localparam int AW     = pmla_pkg::AW;
    localparam int NM     = pmla_pkg::NUM_METHODS;
    localparam int FB     = pmla_pkg::FRAC_BITS;
    localparam int TIME_W = pmla_pkg::TIME_W;
    localparam int CNT_W  = pmla_pkg::CNT_W;
    localparam int TAVG_W = pmla_pkg::TAVG_W;
    localparam int RAVG_W = pmla_pkg::RAVG_W;
    localparam int COEF_W = pmla_pkg::COEF_W;
    localparam int TP1_W  = TAVG_W + COEF_W;
    localparam int TP2_W  = TIME_W + COEF_W;
    localparam int RP1_W  = RAVG_W + COEF_W;
    localparam int RP2_W  = CNT_W + COEF_W;
    localparam int NA     = pmla_pkg::NUM_AVG;

    // per-method tables
    logic [CNT_W-1:0]  count_mem  [NM];
    logic [CNT_W-1:0]  prior_mem  [NM];
    logic [TIME_W-1:0] latest_mem [NM];
    logic [TAVG_W-1:0] tavg_mem   [pmla_pkg::AVG_DEPTH];
    logic [RAVG_W-1:0] ravg_mem   [pmla_pkg::AVG_DEPTH];

    // flags: seen[] gates count reads, avg_valid[] gates prior and average reads
    logic [NM-1:0]                seen_reg;
    logic [NM-1:0]                avg_valid_reg;
    logic                         any_seen_reg;
    logic [MW-1:0]                max_seen_reg;
    logic [pmla_pkg::MASK_W-1:0]  excluded_mask_reg;

    logic [MW-1:0]     call_idx_reg;
    logic [TIME_W-1:0] call_time_reg;

    logic [CNT_W-1:0]  count_rd_reg;
    logic              count_vld_reg;
    logic [CNT_W-1:0]  prior_rd_reg;
    logic [TIME_W-1:0] latest_rd_reg;
    logic              aval_rd_reg;
    logic [TAVG_W-1:0] tavg_rd_reg;
    logic [RAVG_W-1:0] ravg_rd_reg;

    logic [CNT_W-1:0]  delta_reg;
    logic [TP1_W-1:0]  tp1_reg;
    logic [TP2_W-1:0]  tp2_reg;
    logic [RP1_W-1:0]  rp1_reg;
    logic [RP2_W-1:0]  rp2_reg;

    logic [TIME_W-1:0] res_t_reg [NA];
    logic [CNT_W-1:0]  res_r_reg [NA];

    logic                        out_valid_reg;
    logic [pmla_pkg::IDX_W-1:0]  out_id_reg;
    logic [TIME_W-1:0]           out_t_reg [NA];
    logic [CNT_W-1:0]            out_r_reg [NA];
    logic                        out_last_reg;

    logic [MW-1:0]     req_idx;
    logic              idx_in_range;
    logic [MW-1:0]     cnt_addr;
    logic [AW-1:0]     avg_base;
    logic [AW-1:0]     avg_wr_addr;
    logic [AW-1:0]     avg_rd_addr;
    logic [pmla_pkg::K_W-1:0] rd_k;
    logic              avg_rd;
    logic [CNT_W-1:0]  count_eff;
    logic [CNT_W-1:0]  prior_eff;
    logic [TAVG_W-1:0] tavg_eff;
    logic [RAVG_W-1:0] ravg_eff;
    logic [TAVG_W-1:0] new_t;
    logic [RAVG_W-1:0] new_r;
    logic              out_take;

    assign req_idx      = MW'(req.method_index);
    assign idx_in_range = int'(req.method_index) < NM;
    assign cnt_addr     = cmd.call_rd ? req_idx : cmd.m;

    assign avg_base    = AW'({cmd.m, 1'b0}) + AW'(cmd.m);
    assign avg_wr_addr = avg_base + AW'(cmd.k);
    assign rd_k        = cmd.tick_rd ? '0 : cmd.k + 1'b1;
    assign avg_rd_addr = avg_base + AW'(rd_k);
    assign avg_rd      = cmd.tick_rd || (cmd.add && (cmd.k != pmla_pkg::K_LAST));

    assign count_eff = count_vld_reg ? count_rd_reg : '0;
    assign prior_eff = aval_rd_reg ? prior_rd_reg : '0;
    assign tavg_eff  = aval_rd_reg ? tavg_rd_reg : '0;
    assign ravg_eff  = aval_rd_reg ? ravg_rd_reg : '0;

    // convex mix: (avg*e >> 11) + n*(2048-e); never leaves its width
    assign new_t = TAVG_W'(tp1_reg >> FB) + TAVG_W'(tp2_reg);
    assign new_r = RAVG_W'(rp1_reg >> FB) + RAVG_W'(rp2_reg);

    assign out_take = rsp.valid && rsp.ready;

    // status
    assign sts.call_ok  = idx_in_range &&
                          (seen_reg[req_idx] || !excluded_mask_reg[req.method_index]);
    assign sts.any_seen = any_seen_reg;
    assign sts.seen_cur = seen_reg[cmd.m];
    assign sts.is_last  = (cmd.m == max_seen_reg);
    assign sts.out_free = !out_valid_reg || rsp.ready;

    assign cfg.ready = 1'b1;

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg          <= '0;
            avg_valid_reg     <= '0;
            any_seen_reg      <= 1'b0;
            max_seen_reg      <= '0;
            excluded_mask_reg <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
                excluded_mask_reg <= cfg.data;
            if (cmd.call_wr)
            begin
                seen_reg[call_idx_reg] <= 1'b1;
                any_seen_reg           <= 1'b1;
                if (!any_seen_reg || (call_idx_reg > max_seen_reg))
                    max_seen_reg <= call_idx_reg;
            end
            if (cmd.add && (cmd.k == pmla_pkg::K_LAST))
                avg_valid_reg[cmd.m] <= 1'b1;
            if (cmd.emit)
                out_valid_reg <= 1'b1;
            else if (out_take)
                out_valid_reg <= 1'b0;
        end
    end

    // table reads and writes
    always_ff @(posedge clk)
    begin
        if (cmd.call_rd || cmd.tick_rd)
        begin
            count_rd_reg  <= count_mem[cnt_addr];
            count_vld_reg <= seen_reg[cnt_addr];
        end
        if (cmd.tick_rd)
        begin
            prior_rd_reg  <= prior_mem[cmd.m];
            latest_rd_reg <= latest_mem[cmd.m];
            aval_rd_reg   <= avg_valid_reg[cmd.m];
        end
        if (avg_rd)
        begin
            tavg_rd_reg <= tavg_mem[avg_rd_addr];
            ravg_rd_reg <= ravg_mem[avg_rd_addr];
        end
        if (cmd.call_wr)
        begin
            count_mem[call_idx_reg]  <= count_eff + 1'b1;
            latest_mem[call_idx_reg] <= call_time_reg;
        end
        if (cmd.load)
            prior_mem[cmd.m] <= count_eff;
        if (cmd.add)
        begin
            tavg_mem[avg_wr_addr] <= new_t;
            ravg_mem[avg_wr_addr] <= new_r;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (cmd.call_rd)
        begin
            call_idx_reg  <= req_idx;
            call_time_reg <= req.call_time;
        end
        if (cmd.load)
            delta_reg <= count_eff - prior_eff;
        if (cmd.mul)
        begin
            tp1_reg <= TP1_W'(tavg_eff) * TP1_W'(pmla_pkg::decay_coef(cmd.k));
            tp2_reg <= TP2_W'(latest_rd_reg) * TP2_W'(pmla_pkg::decay_comp(cmd.k));
            rp1_reg <= RP1_W'(ravg_eff) * RP1_W'(pmla_pkg::decay_coef(cmd.k));
            rp2_reg <= RP2_W'(delta_reg) * RP2_W'(pmla_pkg::decay_comp(cmd.k));
        end
        if (cmd.add)
        begin
            res_t_reg[cmd.k] <= new_t[TAVG_W-1:FB];
            res_r_reg[cmd.k] <= new_r[RAVG_W-1:FB];
        end
        if (cmd.emit)
        begin
            out_id_reg   <= pmla_pkg::IDX_W'(cmd.m);
            out_t_reg    <= res_t_reg;
            out_r_reg    <= res_r_reg;
            out_last_reg <= sts.is_last;
        end
    end

    assign rsp.valid           = out_valid_reg;
    assign rsp.method_id       = out_id_reg;
    assign rsp.mean_time_short = out_t_reg[0];
    assign rsp.mean_time_mid   = out_t_reg[1];
    assign rsp.mean_time_long  = out_t_reg[2];
    assign rsp.rate_short      = out_r_reg[0];
    assign rsp.rate_mid        = out_r_reg[1];
    assign rsp.rate_long       = out_r_reg[2];
    assign rsp.last            = out_last_reg;

endmodule

FILE: design/per_method_load_average_stats_core.sv
// Channel | Dir | Payload                                              | Transfer when
// req     | in  | opcode, method_index, call_time                      | valid & ready
// rsp     | out | method_id, mean_time_short/mid/long, rate_*, last    | valid & ready
// cfg     | in  | data = excluded_mask                                 | valid & ready
//
// A call reads the table at the transfer and writes count/time in the next cycle.
// A call that is dropped (out of range or excluded and unseen) writes nothing.
// A tick walks the indices up to the highest seen one, stepping past each unseen
// one, and per seen method runs scan, load, 3 multiply/add pairs on the shared
// pair and a load of the output register.
// Reset clears the flags and the mask; the tables read as zero until written.
// A full output register stalls the tick walk; req is held off during a walk.
module per_method_load_average_stats_core (
    input  logic        clk,
    input  logic        rst_n,
    pmla_req_if.sink    req,
    pmla_rsp_if.source  rsp,
    pmla_cfg_if.sink    cfg
);

    pmla_pkg::pmla_cmd_t cmd;
    pmla_pkg::pmla_sts_t sts;

    // sequencer: owns the method and step counters
    pmla_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req.valid),
        .req_opcode (req.opcode),
        .req_ready  (req.ready),
        .sts        (sts),
        .cmd        (cmd)
    );

    // tables, blend arithmetic and output register
    pmla_dp u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp),
        .cfg   (cfg),
        .cmd   (cmd),
        .sts   (sts)
    );

    // a result is only loaded when the output slot frees up
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> sts.out_free)
        else $error("result loaded over a pending transfer");

    // the count write always follows an accepted call
    a_call_wr: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.call_wr |-> $past(req.valid && req.ready && (req.opcode == pmla_pkg::OP_CALL)))
        else $error("call write without call transfer");

    // a tick with seen methods holds off new requests
    a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready && (req.opcode == pmla_pkg::OP_TICK) && sts.any_seen)
        |=> !req.ready)
        else $error("request taken during tick walk");

    // after the last result of a walk the block is ready again
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit && sts.is_last) |=> req.ready)
        else $error("walk did not end after last result");

endmodule
